### rtl/hue_key_pixel_filter_macros.svh
// Assertion macros shared by the hue key pixel filter RTL
`ifndef HUE_KEY_PIXEL_FILTER_MACROS_SVH
`define HUE_KEY_PIXEL_FILTER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define HKF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hkf: assertion failed");
// Next-cycle implication, disabled during reset
`define HKF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hkf: assertion failed");
`else
`define HKF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HKF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/hkf_pkg.sv
// Shared types, constants and helpers of the hue key pixel filter
package hkf_pkg;

  localparam int HUE_FRAC_BITS_DEF = 6;
  localparam int HUE_OUT_W         = 15;
  localparam int CFG_AW            = 4;
  localparam int CFG_DW            = 32;
  localparam int TOL_W             = 9;

  typedef enum logic [1:0] {
    REG_REF_RED,
    REG_REF_GREEN,
    REG_REF_BLUE,
    REG_HUE_TOL
  } reg_idx_t;

  localparam logic [7:0]       RST_REF_RED   = 8'd217;
  localparam logic [7:0]       RST_REF_GREEN = 8'd200;
  localparam logic [7:0]       RST_REF_BLUE  = 8'd170;
  localparam logic [TOL_W-1:0] RST_HUE_TOL   = 9'd1;
  localparam logic [7:0]       WHITE_LEVEL   = 8'hFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]           out_red;
    logic [7:0]           out_green;
    logic [7:0]           out_blue;
    logic [HUE_OUT_W-1:0] hue;
    logic [7:0]           saturation;
    logic [7:0]           brightness;
    logic                 whitened;
  } pix_out_t;

  // width of a hue below 360 degrees on a grid of 2^frac_bits steps per degree
  function automatic int hue_w(input int frac_bits);
    return $clog2(360 * (1 << frac_bits));
  endfunction

endpackage

### rtl/hkf_stream_if.sv
// Valid/ready stream channel carrying one item per handshake
interface hkf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/hkf_hsv.sv
// Pipelined RGB to HSV conversion with two-bit-per-stage divider pipelines
`include "hue_key_pixel_filter_macros.svh"
module hkf_hsv #(
  parameter int  HUE_FRAC_BITS = hkf_pkg::HUE_FRAC_BITS_DEF,
  localparam int HW            = hkf_pkg::hue_w(HUE_FRAC_BITS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hkf_pkg::rgb_t in_pix,
  output logic          out_valid,
  input  logic          out_ready,
  output hkf_pkg::rgb_t out_pix,
  output logic [HW-1:0] out_hue,
  output logic [7:0]    out_sat,
  output logic [7:0]    out_val
);

  localparam int ONE   = 1 << HUE_FRAC_BITS;
  localparam int SCALE = 60 * ONE;
  localparam int QW    = $clog2(SCALE + 1);
  localparam int DQW   = (QW > 8) ? QW : 8;
  localparam int AW    = 8 + DQW;
  localparam int DS    = (DQW + 1) / 2;
  localparam int NS    = DS + 3;
  localparam int LAST  = NS - 1;

  localparam logic [HW-1:0] HUE_120 = HW'(120 * ONE);
  localparam logic [HW-1:0] HUE_240 = HW'(240 * ONE);
  localparam logic [HW-1:0] HUE_360 = HW'(360 * ONE);

  typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} sector_t;

  typedef struct packed {
    hkf_pkg::rgb_t pix;
    logic [7:0]    mx;
    logic [7:0]    dlt;
    logic [7:0]    num;
    sector_t       sec;
    logic          up;
    logic [AW-1:0] acc_h;
    logic [AW-1:0] acc_s;
  } stage_t;

  stage_t        stg_r   [NS];
  stage_t        stg_nxt [NS];
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] vld_shift;
  logic [NS:0]   adv;
  logic [HW-1:0] hue_r;
  logic [HW-1:0] hue_nxt;
  logic [7:0]    sat_r;
  logic [7:0]    sat_nxt;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  function automatic logic [AW-1:0] div_step(input logic [AW-1:0] acc,
                                             input logic [7:0]    dvs);
    logic [8:0] part;
    logic       qb;
    part = acc[AW-1:DQW-1];
    qb   = part >= {1'b0, dvs};
    if (qb) begin
      part = part - {1'b0, dvs};
    end
    return {part[7:0], acc[DQW-2:0], qb};
  endfunction

  // a stage advances when empty or when the stage after it advances
  assign adv[NS] = out_ready;
  for (genvar i = 0; i < NS; i++) begin : g_adv
    assign adv[i] = !vld_r[i] || adv[i+1];
  end

  assign vld_shift = {vld_r[NS-2:0], in_valid};
  assign vld_nxt   = (adv[NS-1:0] & vld_shift) | (~adv[NS-1:0] & vld_r);

  // sort: max, delta, sector and the numerator of the sector offset
  always_comb begin
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] mn;
    r = in_pix.red;
    g = in_pix.green;
    b = in_pix.blue;
    stg_nxt[0]     = '0;
    stg_nxt[0].pix = in_pix;
    if (r >= g && r >= b) begin
      stg_nxt[0].sec = SEC_RED;
      stg_nxt[0].mx  = r;
      stg_nxt[0].up  = g < b;
      stg_nxt[0].num = (g >= b) ? g - b : b - g;
    end else if (g >= b) begin
      stg_nxt[0].sec = SEC_GREEN;
      stg_nxt[0].mx  = g;
      stg_nxt[0].up  = b < r;
      stg_nxt[0].num = (b >= r) ? b - r : r - b;
    end else begin
      stg_nxt[0].sec = SEC_BLUE;
      stg_nxt[0].mx  = b;
      stg_nxt[0].up  = r < g;
      stg_nxt[0].num = (r >= g) ? r - g : g - r;
    end
    if (r <= g && r <= b) begin
      mn = r;
    end else if (g <= b) begin
      mn = g;
    end else begin
      mn = b;
    end
    stg_nxt[0].dlt = stg_nxt[0].mx - mn;
  end

  // scale: dividends for hue offset and saturation
  always_comb begin
    stg_nxt[1]       = stg_r[0];
    stg_nxt[1].acc_h = AW'(32'(stg_r[0].num) * 32'(SCALE));
    stg_nxt[1].acc_s = AW'({stg_r[0].dlt, 8'h00}) - AW'(stg_r[0].dlt);
  end

  // divide: two quotient bits per stage for both dividers
  for (genvar j = 0; j < DS; j++) begin : g_div
    always_comb begin
      stg_nxt[j+2] = stg_r[j+1];
      for (int k = 0; k < 2; k++) begin
        if (j * 2 + k < DQW) begin
          stg_nxt[j+2].acc_h = div_step(stg_nxt[j+2].acc_h, stg_r[j+1].dlt);
          stg_nxt[j+2].acc_s = div_step(stg_nxt[j+2].acc_s, stg_r[j+1].mx);
        end
      end
    end
  end

  // assemble: sector base plus or minus the offset, rounded up below the base; zero hue for gray
  always_comb begin
    logic [HW-1:0] off;
    logic          rnz;
    stg_nxt[LAST] = stg_r[LAST-1];
    rnz = |stg_r[LAST-1].acc_h[AW-1:DQW];
    off = HW'(stg_r[LAST-1].acc_h[DQW-1:0]) + HW'(stg_r[LAST-1].up & rnz);
    case (stg_r[LAST-1].sec)
      SEC_RED:   hue_nxt = stg_r[LAST-1].up ? HUE_360 - off : off;
      SEC_GREEN: hue_nxt = stg_r[LAST-1].up ? HUE_120 - off : HUE_120 + off;
      SEC_BLUE:  hue_nxt = stg_r[LAST-1].up ? HUE_240 - off : HUE_240 + off;
      default:   hue_nxt = '0;
    endcase
    if (stg_r[LAST-1].dlt == 8'd0) begin
      hue_nxt = '0;
    end
    sat_nxt = (stg_r[LAST-1].mx == 8'd0) ? 8'd0 : stg_r[LAST-1].acc_s[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (adv[i]) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
    if (adv[LAST]) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[LAST];
  assign out_pix   = stg_r[LAST].pix;
  assign out_hue   = hue_r;
  assign out_sat   = sat_r;
  assign out_val   = stg_r[LAST].mx;

  `HKF_ASSERT_IMP(a_hue_range, clk, rst_n, out_valid, out_hue < HUE_360)
  `HKF_ASSERT_IMP(a_gray_hue, clk, rst_n, out_valid && out_sat == 8'd0, out_hue == '0)
  `HKF_ASSERT_NXT(a_hold_hue, clk, rst_n, out_valid && !out_ready, $stable(hue_r))

endmodule

### rtl/hkf_key.sv
// Hue distance against the reference, tolerance compare and result register
`include "hue_key_pixel_filter_macros.svh"
module hkf_key #(
  parameter int  HUE_FRAC_BITS = hkf_pkg::HUE_FRAC_BITS_DEF,
  localparam int HW            = hkf_pkg::hue_w(HUE_FRAC_BITS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hkf_pkg::rgb_t               in_pix,
  input  logic [HW-1:0]               in_hue,
  input  logic [7:0]                  in_sat,
  input  logic [7:0]                  in_val,
  input  logic [HW-1:0]               ref_hue,
  input  logic [hkf_pkg::TOL_W-1:0]   tolerance,
  hkf_stream_if.source                res
);

  localparam int XW = HW + hkf_pkg::HUE_OUT_W;

  logic              vld_a_r;
  logic              vld_b_r;
  logic              adv_a;
  logic              adv_b;
  hkf_pkg::rgb_t     pix_a_r;
  logic [HW-1:0]     hue_a_r;
  logic [7:0]        sat_a_r;
  logic [7:0]        val_a_r;
  logic [HW-1:0]     diff_a_r;
  logic [HW-1:0]     diff_nxt;
  logic              white;
  logic [XW-1:0]     hue_ext;
  hkf_pkg::pix_out_t res_r;
  hkf_pkg::pix_out_t res_nxt;

  assign adv_b    = !vld_b_r || res.ready;
  assign adv_a    = !vld_a_r || adv_b;
  assign in_ready = adv_a;

  assign diff_nxt = (in_hue >= ref_hue) ? in_hue - ref_hue : ref_hue - in_hue;

  // whole-degree difference, no wrap at 360
  assign white   = (diff_a_r >> HUE_FRAC_BITS) > HW'(tolerance);
  assign hue_ext = XW'(hue_a_r);

  always_comb begin
    res_nxt.out_red    = white ? hkf_pkg::WHITE_LEVEL : pix_a_r.red;
    res_nxt.out_green  = white ? hkf_pkg::WHITE_LEVEL : pix_a_r.green;
    res_nxt.out_blue   = white ? hkf_pkg::WHITE_LEVEL : pix_a_r.blue;
    res_nxt.hue        = hue_ext[hkf_pkg::HUE_OUT_W-1:0];
    res_nxt.saturation = sat_a_r;
    res_nxt.brightness = val_a_r;
    res_nxt.whitened   = white;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (adv_a) begin
        vld_a_r <= in_valid;
      end
      if (adv_b) begin
        vld_b_r <= vld_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      pix_a_r  <= in_pix;
      hue_a_r  <= in_hue;
      sat_a_r  <= in_sat;
      val_a_r  <= in_val;
      diff_a_r <= diff_nxt;
    end
    if (adv_b) begin
      res_r <= res_nxt;
    end
  end

  assign res.valid = vld_b_r;
  assign res.data  = res_r;

  `HKF_ASSERT_IMP(a_white_pix, clk, rst_n, res.valid && res.data.whitened,
    {res.data.out_red, res.data.out_green, res.data.out_blue} == {3{hkf_pkg::WHITE_LEVEL}})

endmodule

### rtl/hue_key_pixel_filter.sv
// Top level of the hue key pixel filter: register file, converters and key stage
//
// Usage
//   in_pix  : valid/ready stream of RGB pixels, one item per handshake.
//   out_pix : valid/ready stream of results: the pixel (white when its hue
//             is too far from the reference hue), its hue in 1/2^HUE_FRAC_BITS
//             degree, saturation, brightness and a whitened flag.
//   APB     : four write/read registers at byte addresses 0, 4, 8, 12:
//             reference red, green, blue and the hue tolerance in degrees.
//             Write them only while no item is in flight.
// Timing
//   One item is accepted every cycle while the receiver takes results. Items
//   pass the sort, scale, DS divider and assemble stages, then the key stage's
//   difference and result registers; DS = ceil(max(QW, 8) / 2), QW the width
//   of 60 * 2^HUE_FRAC_BITS. The two-bit-per-stage divider pipeline sets the depth.
// Reset and stall
//   Reset empties the pipeline and loads the default reference colour and
//   tolerance. When the receiver stalls, items close up into empty stages
//   and in_pix.ready drops only once every stage, the output too, is full.
`include "hue_key_pixel_filter_macros.svh"
module hue_key_pixel_filter #(
  parameter int HUE_FRAC_BITS = hkf_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  hkf_stream_if.sink                  in_pix,
  hkf_stream_if.source                out_pix,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hkf_pkg::CFG_AW-1:0]  paddr,
  input  logic [hkf_pkg::CFG_DW-1:0]  pwdata,
  output logic [hkf_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int HW = hkf_pkg::hue_w(HUE_FRAC_BITS);

  // register file
  logic [7:0]                ref_red_r;
  logic [7:0]                ref_red_nxt;
  logic [7:0]                ref_green_r;
  logic [7:0]                ref_green_nxt;
  logic [7:0]                ref_blue_r;
  logic [7:0]                ref_blue_nxt;
  logic [hkf_pkg::TOL_W-1:0] tol_r;
  logic [hkf_pkg::TOL_W-1:0] tol_nxt;
  logic                      cfg_wr;
  hkf_pkg::reg_idx_t         cfg_idx;

  // pixel conversion to key stage
  logic                      cv_valid;
  logic                      cv_ready;
  hkf_pkg::rgb_t             cv_pix;
  logic [HW-1:0]             cv_hue;
  logic [7:0]                cv_sat;
  logic [7:0]                cv_val;
  hkf_pkg::rgb_t             pix_in;

  // reference conversion
  hkf_pkg::rgb_t             ref_pix;
  logic [HW-1:0]             ref_hue;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = hkf_pkg::reg_idx_t'(paddr[hkf_pkg::CFG_AW-1:2]);

  // take a write on the access cycle; keep only the register's own bits
  always_comb begin
    ref_red_nxt   = ref_red_r;
    ref_green_nxt = ref_green_r;
    ref_blue_nxt  = ref_blue_r;
    tol_nxt       = tol_r;
    if (cfg_wr) begin
      case (cfg_idx)
        hkf_pkg::REG_REF_RED:   ref_red_nxt   = pwdata[7:0];
        hkf_pkg::REG_REF_GREEN: ref_green_nxt = pwdata[7:0];
        hkf_pkg::REG_REF_BLUE:  ref_blue_nxt  = pwdata[7:0];
        hkf_pkg::REG_HUE_TOL:   tol_nxt       = pwdata[hkf_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hkf_pkg::REG_REF_RED:   prdata = hkf_pkg::CFG_DW'(ref_red_r);
      hkf_pkg::REG_REF_GREEN: prdata = hkf_pkg::CFG_DW'(ref_green_r);
      hkf_pkg::REG_REF_BLUE:  prdata = hkf_pkg::CFG_DW'(ref_blue_r);
      hkf_pkg::REG_HUE_TOL:   prdata = hkf_pkg::CFG_DW'(tol_r);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_red_r   <= hkf_pkg::RST_REF_RED;
      ref_green_r <= hkf_pkg::RST_REF_GREEN;
      ref_blue_r  <= hkf_pkg::RST_REF_BLUE;
      tol_r       <= hkf_pkg::RST_HUE_TOL;
    end else begin
      ref_red_r   <= ref_red_nxt;
      ref_green_r <= ref_green_nxt;
      ref_blue_r  <= ref_blue_nxt;
      tol_r       <= tol_nxt;
    end
  end

  assign pix_in = '{red:   in_pix.data.pix_red,
                    green: in_pix.data.pix_green,
                    blue:  in_pix.data.pix_blue};

  // Feed the reference converter from the next register values so that its
  // hue is settled no later than that of a pixel taken on the write edge.
  // It runs free; the registers must not change while items are in flight (not enforced).
  assign ref_pix = '{red: ref_red_nxt, green: ref_green_nxt, blue: ref_blue_nxt};

  hkf_hsv #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_pix_hsv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .in_pix    (pix_in),
    .out_valid (cv_valid),
    .out_ready (cv_ready),
    .out_pix   (cv_pix),
    .out_hue   (cv_hue),
    .out_sat   (cv_sat),
    .out_val   (cv_val)
  );

  hkf_hsv #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_ref_hsv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (1'b1),
    .in_ready  (),
    .in_pix    (ref_pix),
    .out_valid (),
    .out_ready (1'b1),
    .out_pix   (),
    .out_hue   (ref_hue),
    .out_sat   (),
    .out_val   ()
  );

  // compare against the reference hue, whiten and hold the result item
  hkf_key #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cv_valid),
    .in_ready  (cv_ready),
    .in_pix    (cv_pix),
    .in_hue    (cv_hue),
    .in_sat    (cv_sat),
    .in_val    (cv_val),
    .ref_hue   (ref_hue),
    .tolerance (tol_r),
    .res       (out_pix)
  );

  `HKF_ASSERT_IMP(a_ready_full, clk, rst_n, !in_pix.ready, out_pix.valid)

endmodule
